// ===== rtl/b64enc_pkg.sv =====
// Shared types, constants and the character map of the base64 stream encoder.
// Used by every module under rtl/; depends on nothing.
package b64enc_pkg;

   // Group queue between the byte front and the character back; depth is a power of two.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [6:0] PAD_CHAR   = 7'h3D;  // '='
   localparam logic [6:0] PLUS_CHAR  = 7'h2B;  // '+'
   localparam logic [6:0] SLASH_CHAR = 7'h2F;  // '/'
   localparam logic [6:0] UPPER_OFS  = 7'd65;  // 'A'
   localparam logic [6:0] LOWER_OFS  = 7'd71;  // 'a' - 26
   localparam logic [6:0] DIGIT_OFS  = 7'd4;   // 52 - '0'

   localparam logic [1:0] SEXT_LAST = 2'd3;

   // One 24-bit group; held is the number of bytes pending before the closing byte (0..2).
   typedef struct packed {
      logic [23:0] bits;
      logic [1:0]  held;
      logic        last;
   } group_type;

   function automatic logic [6:0] b64_char(input logic [5:0] v);
      logic [6:0] code;
      if (v < 6'd26) begin
         code = 7'(v) + UPPER_OFS;
      end else if (v < 6'd52) begin
         code = 7'(v) + LOWER_OFS;
      end else if (v < 6'd62) begin
         code = 7'(v) - DIGIT_OFS;
      end else if (v == 6'd62) begin
         code = PLUS_CHAR;
      end else begin
         code = SLASH_CHAR;
      end
      return code;
   endfunction

endpackage

// ===== rtl/b64enc_front.sv =====
// Byte front end: accepts message bytes, holds up to two, and closes 24-bit groups.
// Depends on b64enc_pkg.
module b64enc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_message_end,
   output logic                  grp_valid,
   input  logic                  grp_ready,
   output b64enc_pkg::group_type grp_data
);
   import b64enc_pkg::*;

   logic [1:0]  pend_cnt_ff, pend_cnt_in;
   logic [15:0] pend_bytes_ff, pend_bytes_in;
   logic        take;
   logic        closes;

   assign req_ready = grp_ready;
   assign take      = req_valid && req_ready;
   assign closes    = req_message_end || (pend_cnt_ff >= 2'd2);
   assign grp_valid = take && closes;

   always_comb begin
      grp_data.held = (pend_cnt_ff > 2'd2) ? 2'd2 : pend_cnt_ff;
      grp_data.last = req_message_end;
      case (grp_data.held)
         2'd0:    grp_data.bits = {req_data_byte, 16'd0};
         2'd1:    grp_data.bits = {pend_bytes_ff[15:8], req_data_byte, 8'd0};
         default: grp_data.bits = {pend_bytes_ff, req_data_byte};
      endcase
   end

   always_comb begin
      pend_cnt_in   = pend_cnt_ff;
      pend_bytes_in = pend_bytes_ff;
      if (take) begin
         if (closes) begin
            pend_cnt_in   = 2'd0;
            pend_bytes_in = 16'd0;
         end else begin
            pend_cnt_in = pend_cnt_ff + 2'd1;
            if (pend_cnt_ff == 2'd0) begin
               pend_bytes_in = {req_data_byte, 8'd0};
            end else begin
               pend_bytes_in = {pend_bytes_ff[15:8], req_data_byte};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff   <= 2'd0;
         pend_bytes_ff <= 16'd0;
      end else begin
         pend_cnt_ff   <= pend_cnt_in;
         pend_bytes_ff <= pend_bytes_in;
      end
   end

endmodule

// ===== rtl/b64enc_fifo.sv =====
// Short group queue that decouples the byte front from the character back.
// Depends on b64enc_pkg.
module b64enc_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  b64enc_pkg::group_type     push_data,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output b64enc_pkg::group_type     pop_data,
   output logic [b64enc_pkg::QCNT_W-1:0] fill
);
   import b64enc_pkg::*;

   group_type            q_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign push_ready = (cnt_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = q_ff[rd_ptr_ff];
   assign fill       = cnt_ff;

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   // Pointers wrap naturally since the depth is a power of two.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/b64enc_back.sv =====
// Character back end: splits each queued group into four sextets and registers one
// ASCII character per cycle unless rsp stalls. Depends on b64enc_pkg.
module b64enc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  grp_valid,
   output logic                  grp_ready,
   input  b64enc_pkg::group_type grp_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [6:0]            rsp_char_code,
   output logic                  rsp_group_end,
   output logic                  rsp_message_done
);
   import b64enc_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [6:0] char_ff, char_in;
   logic       gend_ff, gend_in;
   logic       mdone_ff, mdone_in;
   logic       emit;
   logic [5:0] sext;
   logic       pad;

   // Advance when the output register is empty or being drained.
   assign emit      = grp_valid && (!out_valid_ff || rsp_ready);
   assign grp_ready = emit && (idx_ff == SEXT_LAST);

   always_comb begin
      case (idx_ff)
         2'd0:    sext = grp_data.bits[23:18];
         2'd1:    sext = grp_data.bits[17:12];
         2'd2:    sext = grp_data.bits[11:6];
         default: sext = grp_data.bits[5:0];
      endcase
      pad = ((idx_ff == 2'd2) && (grp_data.held == 2'd0))
         || ((idx_ff == SEXT_LAST) && (grp_data.held != 2'd2));
   end

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      char_in      = char_ff;
      gend_in      = gend_ff;
      mdone_in     = mdone_ff;
      if (emit) begin
         idx_in       = idx_ff + 2'd1;
         out_valid_in = 1'b1;
         char_in      = pad ? PAD_CHAR : b64_char(sext);
         gend_in      = (idx_ff == SEXT_LAST);
         mdone_in     = (idx_ff == SEXT_LAST) && grp_data.last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff  <= char_in;
      gend_ff  <= gend_in;
      mdone_ff <= mdone_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_char_code    = char_ff;
   assign rsp_group_end    = gend_ff;
   assign rsp_message_done = mdone_ff;

endmodule

// ===== rtl/base64_stream_encoder.sv =====
// Top level of the base64 stream encoder: byte front, group queue, character back.
// Depends on b64enc_pkg, b64enc_front, b64enc_fifo and b64enc_back.
//
//   channel | ports                                              | role
//   req     | req_valid req_ready req_data_byte req_message_end  | message bytes in
//   rsp     | rsp_valid rsp_ready rsp_char_code rsp_group_end    | characters out
//           | rsp_message_done                                   |
//
// A byte is taken every cycle while the group queue has room; a closing byte
// needs a free queue slot. Characters leave one per cycle while rsp_ready is high,
// from a single output register. With the back end idle, a group's closing byte
// is written into the group queue, then popped into the output register that
// drives the group's first character.
// Reset clears the held bytes, the queue and the valid flag of the output register.
// A stall on rsp fills the queue, then holds off req; neither side drops data.
module base64_stream_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_message_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_char_code,
   output logic       rsp_group_end,
   output logic       rsp_message_done
);
   import b64enc_pkg::*;

   group_type         push_data, pop_data;
   logic              push_valid, push_ready;
   logic              pop_valid, pop_ready;
   logic [QCNT_W-1:0] q_fill;

   b64enc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_message_end (req_message_end),
      .grp_valid       (push_valid),
      .grp_ready       (push_ready),
      .grp_data        (push_data)
   );

   b64enc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .fill       (q_fill)
   );

   b64enc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .grp_valid        (pop_valid),
      .grp_ready        (pop_ready),
      .grp_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_char_code    (rsp_char_code),
      .rsp_group_end    (rsp_group_end),
      .rsp_message_done (rsp_message_done)
   );

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      q_fill <= QCNT_W'(QDEPTH))
      else $error("group queue over capacity");

   a_done_ends_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_done |-> rsp_group_end)
      else $error("message end outside a group end");

   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      q_fill == QCNT_W'(QDEPTH) |-> !req_ready)
      else $error("byte accepted with full queue");

   a_reset_clears_out: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");
`endif

endmodule

// ===== test/b64enc_checker.sv =====
`timescale 1ns / 100ps
// Watches both channels of the base64 stream encoder, predicts each character
// from the accepted bytes and compares it on the rsp channel. Depends on b64enc_pkg.
module b64enc_checker
   import b64enc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_message_end,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [6:0] rsp_char_code,
   input  logic       rsp_group_end,
   input  logic       rsp_message_done,
   output int         mismatch_count,
   output int         chars_outstanding,
   output int         chars_checked
);

   typedef struct packed {
      logic [6:0] code;
      logic       group_end;
      logic       message_done;
   } b64_char_type;

   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   b64_char_type expected_chars[$];
   logic [1:0]   held_count = 2'd0;
   logic [15:0]  held_bytes = 16'h0000;
   int           mismatches = 0;
   int           compared   = 0;

   initial begin
      mismatch_count    = 0;
      chars_outstanding = 0;
      chars_checked     = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
   endtask

   function automatic logic [6:0] sextet_char(input logic [5:0] v);
      int idx;
      idx = 8 * (63 - int'(v));
      return ALPHABET[idx +: 7];
   endfunction

   // Hold the byte, or close the group and queue its four characters.
   task automatic encode_byte(input logic [7:0] data, input logic is_last);
      logic [23:0]  grp_bits;
      int           have;
      int           k;
      b64_char_type c;
      if (held_count < 2'd2 && !is_last) begin
         if (held_count == 2'd0) begin
            held_bytes = {data, 8'h00};
         end else begin
            held_bytes[7:0] = data;
         end
         held_count = held_count + 2'd1;
      end else begin
         case (held_count)
            2'd0: begin
               grp_bits = {data, 16'h0000};
            end
            2'd1: begin
               grp_bits = {held_bytes[15:8], data, 8'h00};
            end
            default: begin
               grp_bits = {held_bytes, data};
            end
         endcase
         have = (held_count > 2'd2) ? 3 : int'(held_count) + 1;
         for (k = 0; k < 4; k++) begin
            if ((k == 2 && have < 2) || (k == 3 && have < 3)) begin
               c.code = PAD_CHAR;
            end else begin
               c.code = sextet_char(grp_bits[18 - 6 * k +: 6]);
            end
            c.group_end    = (k == 3);
            c.message_done = (k == 3) && is_last;
            expected_chars.insert(expected_chars.size(), c);
         end
         held_count = 2'd0;
         held_bytes = 16'h0000;
      end
   endtask

   always @(posedge clock) begin
      b64_char_type want;
      if (reset) begin
         expected_chars.delete();
         held_count = 2'd0;
         held_bytes = 16'h0000;
      end else begin
         if (req_valid && req_ready) begin
            encode_byte(req_data_byte, req_message_end);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("character 0x%0h with nothing pending", rsp_char_code));
            end else begin
               want = expected_chars.pop_front();
               compared++;
               if (rsp_char_code !== want.code) begin
                  report_mismatch($sformatf("char_code got 0x%0h expected 0x%0h",
                                            rsp_char_code, want.code));
               end
               if (rsp_group_end !== want.group_end) begin
                  report_mismatch($sformatf("group_end got %0b expected %0b",
                                            rsp_group_end, want.group_end));
               end
               if (rsp_message_done !== want.message_done) begin
                  report_mismatch($sformatf("message_done got %0b expected %0b",
                                            rsp_message_done, want.message_done));
               end
            end
         end
      end
      mismatch_count    <= mismatches;
      chars_outstanding <= expected_chars.size();
      chars_checked     <= compared;
   end

endmodule

// ===== test/tb_base64_stream_encoder.sv =====
`timescale 1ns / 100ps
// Top of the base64 stream encoder testbench: clock, reset, byte stimulus and rsp stalls.
// Depends on b64enc_pkg, base64_stream_encoder and b64enc_checker.
module tb_base64_stream_encoder;

   localparam int RANDOM_BYTES = 410;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PCT     = 28;
   localparam int CALM_FIRST   = 150;
   localparam int CALM_LAST    = 260;
   localparam int DIRECTED_N   = 19;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte   = 8'h00;
   logic       req_message_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready       = 1'b0;
   logic [6:0] rsp_char_code;
   logic       rsp_group_end;
   logic       rsp_message_done;

   int mismatch_count;
   int chars_outstanding;
   int chars_checked;
   int bytes_sent    = 0;
   int messages_sent = 0;
   int cycle_count   = 0;

   // {message_end, data_byte}: single-byte and two-byte tails, full groups,
   // all-zero and all-one bytes, and groups that map to '+' and '/'.
   logic [8:0] directed_items [DIRECTED_N] = '{
      9'h100,
      9'h1FF,
      9'h0FF, 9'h1FF,
      9'h000, 9'h000, 9'h100,
      9'h0FB, 9'h0EF, 9'h1BE,
      9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,
      9'h04D, 9'h061, 9'h06E, 9'h04D, 9'h161
   };

   wire calm = (bytes_sent >= CALM_FIRST) && (bytes_sent < CALM_LAST);

   base64_stream_encoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_message_end  (req_message_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_char_code    (rsp_char_code),
      .rsp_group_end    (rsp_group_end),
      .rsp_message_done (rsp_message_done)
   );

   b64enc_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_message_end   (req_message_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_char_code     (rsp_char_code),
      .rsp_group_end     (rsp_group_end),
      .rsp_message_done  (rsp_message_done),
      .mismatch_count    (mismatch_count),
      .chars_outstanding (chars_outstanding),
      .chars_checked     (chars_checked)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Present one byte and hold it until the transaction completes.
   task automatic send_byte(input logic [7:0] data, input logic is_last);
      // Insert idle cycles at random so the idle share stays near IDLE_PCT.
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= data;
      req_message_end <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      if (is_last) begin
         messages_sent++;
      end
   endtask

   initial begin
      int i;
      int len;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_N; i++) begin
         send_byte(directed_items[i][7:0], directed_items[i][8]);
      end

      // Mostly short messages so every tail length shows up often.
      while (bytes_sent < DIRECTED_N + RANDOM_BYTES) begin
         len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 9) : $urandom_range(10, 40);
         for (i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
         end
      end
      req_valid <= 1'b0;

      // Let the checker see the last accepted byte before draining.
      @(posedge clock);
      while (chars_outstanding != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Sent %0d bytes in %0d messages, directed tails first, then random lengths",
               bytes_sent, messages_sent);
      $display("Compared %0d characters, %0d still pending", chars_checked, chars_outstanding);
      if (mismatch_count == 0 && chars_outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
